/* src/cpa_pkg.sv */
// Shared types and constants for the channel pool allocator.
package cpa_pkg;

    // Request codes carried on the mode field.
    localparam logic [1:0] MODE_ASSIGN  = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    // Fixed widths of the result fields.
    localparam int CHANNEL_W = 5;
    localparam int COUNT_W   = 5;

    // Flags that travel with the search token from cell to cell.
    typedef struct packed {
        logic valid;
        logic found;
        logic has_free;
    } t_scan_flags;

endpackage

/* src/channel_pool_allocator.sv */
// Top level of the channel pool allocator: control, search chain and free list.
//
//   Channel   Signals                                  Handshake
//   request   start, busy, i_mode, i_source_id, i_stop  taken when start && !busy
//   result    o_valid, o_ok ... o_free_available        one-cycle strobe, no stall
//   config    i_cfg_valid, o_cfg_ready, i_cfg_data      beat when valid && ready
//
// The search token walks the row of table cells one cell per cycle, and the update
// and the result register follow at the last cell. busy falls with the strobe,
// so the next request can be taken at the edge that ends it.
// Reset is synchronous and active low; it empties the table and refills the
// free list with channels 0 to NUM_CHANNELS-1 at once, with no sweep.
// The result cannot be stalled; config beats are always accepted.
module channel_pool_allocator #(
    parameter int NUM_CHANNELS   = 24,
    parameter int SOURCE_ID_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_mode,
    input  logic [SOURCE_ID_BITS-1:0]           i_source_id,
    input  logic                                i_stop,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic [cpa_pkg::CHANNEL_W-1:0]       o_channel,
    output logic                                o_was_playing,
    output logic                                o_stop_request,
    output logic [cpa_pkg::COUNT_W-1:0]         o_active_count,
    output logic                                o_free_available
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                      r_state;
    logic                      r_launch;
    logic                      r_track;
    logic [1:0]                r_mode;
    logic [SOURCE_ID_BITS-1:0] r_key;
    logic                      r_stop;
    logic [CNT_W-1:0]          r_active;
    logic [CNT_W-1:0]          n_active;

    logic                      accept;
    logic                      fin;

    cpa_pkg::t_scan_flags      tok      [NUM_CHANNELS+1];
    logic [CH_W-1:0]           hit_idx  [NUM_CHANNELS+1];
    logic [CH_W-1:0]           hit_chan [NUM_CHANNELS+1];
    logic [CH_W-1:0]           free_idx [NUM_CHANNELS+1];
    cpa_pkg::t_scan_flags      last;

    logic                      do_set;
    logic                      do_clr;
    logic                      pop;
    logic                      push;
    logic [CH_W-1:0]           head_chan;
    logic [CNT_W-1:0]          free_count;

    logic                      n_ok;
    logic [CH_W-1:0]           n_chan;
    logic                      n_was;
    logic                      n_stopreq;
    logic                      n_free_avail;
    logic [CH_W+cpa_pkg::CHANNEL_W-1:0] chan_ext;
    logic [CNT_W+cpa_pkg::COUNT_W-1:0]  cnt_ext;

    assign accept      = start && !busy;
    assign busy        = (r_state == ST_SCAN);
    assign o_cfg_ready = 1'b1;
    assign last        = tok[NUM_CHANNELS];
    assign fin         = (r_state == ST_SCAN) && last.valid;

    // Search chain: the token enters cell 0 the cycle after acceptance.
    assign tok[0]      = '{valid: r_launch, found: 1'b0, has_free: 1'b0};
    assign hit_idx[0]  = '0;
    assign hit_chan[0] = '0;
    assign free_idx[0] = '0;

    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
        logic cell_set;
        logic cell_clr;

        assign cell_set = do_set && (free_idx[NUM_CHANNELS] == CH_W'(g));
        assign cell_clr = do_clr && (hit_idx[NUM_CHANNELS] == CH_W'(g));

        cpa_cell #(
            .CELL_IDX (g),
            .SRC_W    (SOURCE_ID_BITS),
            .CH_W     (CH_W),
            .IDX_W    (CH_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (r_key),
            .i_tok      (tok[g]),
            .i_hit_idx  (hit_idx[g]),
            .i_hit_chan (hit_chan[g]),
            .i_free_idx (free_idx[g]),
            .i_set      (cell_set),
            .i_clr      (cell_clr),
            .i_wr_src   (r_key),
            .i_wr_chan  (head_chan),
            .o_tok      (tok[g+1]),
            .o_hit_idx  (hit_idx[g+1]),
            .o_hit_chan (hit_chan[g+1]),
            .o_free_idx (free_idx[g+1])
        );
    end

    cpa_free_list #(
        .NUM_CH (NUM_CHANNELS),
        .CH_W   (CH_W),
        .CNT_W  (CNT_W)
    ) u_free_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .i_push      (push),
        .i_push_chan (hit_chan[NUM_CHANNELS]),
        .o_head_chan (head_chan),
        .o_count     (free_count)
    );

    // Decide the update and the result once the token leaves the last cell.
    always_comb begin
        do_set    = 1'b0;
        do_clr    = 1'b0;
        pop       = 1'b0;
        push      = 1'b0;
        n_ok      = 1'b0;
        n_chan    = '0;
        n_was     = 1'b0;
        n_stopreq = 1'b0;
        n_active  = r_active;
        if (fin) begin
            case (r_mode)
                cpa_pkg::MODE_ASSIGN: begin
                    if (last.found) begin
                        n_ok   = 1'b1;
                        n_was  = 1'b1;
                        n_chan = hit_chan[NUM_CHANNELS];
                    end else if (free_count != '0) begin
                        n_ok   = 1'b1;
                        n_chan = head_chan;
                        pop    = 1'b1;
                        if (r_track && last.has_free) begin
                            do_set   = 1'b1;
                            n_active = r_active + 1'b1;
                        end
                    end
                end
                cpa_pkg::MODE_RELEASE: begin
                    if (last.found) begin
                        n_ok      = 1'b1;
                        n_stopreq = r_stop;
                        push      = 1'b1;
                        do_clr    = 1'b1;
                        n_active  = r_active - 1'b1;
                    end
                end
                cpa_pkg::MODE_QUERY: begin
                    n_ok = last.found;
                end
                default: begin
                end
            endcase
        end
    end

    // Free channel left after this step.
    always_comb begin
        if (pop) begin
            n_free_avail = (free_count > CNT_W'(1));
        end else if (push) begin
            n_free_avail = 1'b1;
        end else begin
            n_free_avail = (free_count != '0);
        end
    end

    assign chan_ext = {{cpa_pkg::CHANNEL_W{1'b0}}, n_chan};
    assign cnt_ext  = {{cpa_pkg::COUNT_W{1'b0}}, n_active};

    // Control state, config register and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_launch <= 1'b0;
            r_track  <= 1'b1;
            r_active <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_launch <= accept;
            o_valid  <= fin;
            r_active <= n_active;
            if (i_cfg_valid && o_cfg_ready) begin
                r_track <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (fin) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_source_id;
            r_stop <= i_stop;
        end
        if (fin) begin
            o_ok             <= n_ok;
            o_channel        <= chan_ext[cpa_pkg::CHANNEL_W-1:0];
            o_was_playing    <= n_was;
            o_stop_request   <= n_stopreq;
            o_active_count   <= cnt_ext[cpa_pkg::COUNT_W-1:0];
            o_free_available <= n_free_avail;
        end
    end

    // A result appears in the cycle after the token leaves the chain.
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (o_valid && !busy))
        else $error("result strobe missing after the search completed");

    // The table never holds more entries than there are channels.
    a_active_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= CNT_W'(NUM_CHANNELS))
        else $error("active entry count exceeds the channel pool");

    // No token enters the chain while a search is already under way.
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_launch |-> !$past(busy))
        else $error("second search launched while busy");

    // A failed request reports channel zero.
    a_fail_zero_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_channel == '0))
        else $error("failed request reported a nonzero channel");

endmodule

/* src/cpa_cell.sv */
// One table entry of the allocator, plus its stage of the search chain.
module cpa_cell #(
    parameter int CELL_IDX = 0,
    parameter int SRC_W    = 16,
    parameter int CH_W     = 5,
    parameter int IDX_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [SRC_W-1:0]     i_key,
    input  cpa_pkg::t_scan_flags i_tok,
    input  logic [IDX_W-1:0]     i_hit_idx,
    input  logic [CH_W-1:0]      i_hit_chan,
    input  logic [IDX_W-1:0]     i_free_idx,
    input  logic                 i_set,
    input  logic                 i_clr,
    input  logic [SRC_W-1:0]     i_wr_src,
    input  logic [CH_W-1:0]      i_wr_chan,
    output cpa_pkg::t_scan_flags o_tok,
    output logic [IDX_W-1:0]     o_hit_idx,
    output logic [CH_W-1:0]      o_hit_chan,
    output logic [IDX_W-1:0]     o_free_idx
);

    logic                 r_valid;
    logic [SRC_W-1:0]     r_source;
    logic [CH_W-1:0]      r_channel;
    cpa_pkg::t_scan_flags r_tok;
    cpa_pkg::t_scan_flags n_tok;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [IDX_W-1:0]     n_hit_idx;
    logic [CH_W-1:0]      r_hit_chan;
    logic [CH_W-1:0]      n_hit_chan;
    logic [IDX_W-1:0]     r_free_idx;
    logic [IDX_W-1:0]     n_free_idx;
    logic                 match;

    assign match = r_valid && (r_source == i_key);

    // An earlier hit or free slot wins, so the lowest index is kept.
    always_comb begin
        n_tok       = i_tok;
        n_hit_idx   = i_hit_idx;
        n_hit_chan  = i_hit_chan;
        n_free_idx  = i_free_idx;
        if (!i_tok.found && match) begin
            n_tok.found = 1'b1;
            n_hit_idx   = IDX_W'(CELL_IDX);
            n_hit_chan  = r_channel;
        end
        if (!i_tok.has_free && !r_valid) begin
            n_tok.has_free = 1'b1;
            n_free_idx     = IDX_W'(CELL_IDX);
        end
    end

    // Entry valid bit and token stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_set) begin
                r_valid <= 1'b1;
            end else if (i_clr) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Entry payload and the data handed to the next cell.
    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_hit_chan <= n_hit_chan;
        r_free_idx <= n_free_idx;
        if (i_set) begin
            r_source  <= i_wr_src;
            r_channel <= i_wr_chan;
        end
    end

    assign o_tok      = r_tok;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_chan = r_hit_chan;
    assign o_free_idx = r_free_idx;

endmodule

/* src/cpa_free_list.sv */
// First-in first-out list of free channels, starting out as 0 to N-1.
module cpa_free_list #(
    parameter int NUM_CH = 24,
    parameter int CH_W   = 5,
    parameter int CNT_W  = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop,
    input  logic             i_push,
    input  logic [CH_W-1:0]  i_push_chan,
    output logic [CH_W-1:0]  o_head_chan,
    output logic [CNT_W-1:0] o_count
);

    logic [CH_W-1:0]   r_mem [NUM_CH];
    logic [NUM_CH-1:0] r_written;
    logic [CH_W-1:0]   r_head;
    logic [CH_W-1:0]   r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CH_W-1:0]   r_rd_data;
    logic              r_rd_written;
    logic [CH_W-1:0]   r_rd_pos;
    logic              full;
    logic              do_push;

    assign full    = (r_count == CNT_W'(NUM_CH));
    assign do_push = i_push && !full;

    // Pointers, count and written marks; an unwritten slot holds its own index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= CNT_W'(NUM_CH);
            r_written <= '0;
        end else begin
            if (i_pop) begin
                r_head  <= (r_head == CH_W'(NUM_CH - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (do_push) begin
                r_tail            <= (r_tail == CH_W'(NUM_CH - 1)) ? '0 : r_tail + 1'b1;
                r_count           <= r_count + 1'b1;
                r_written[r_tail] <= 1'b1;
            end
        end
    end

    // Storage: written at the tail, read at the head with registered data.
    always_ff @(posedge i_clk) begin
        if (do_push && !i_pop) begin
            r_mem[r_tail] <= i_push_chan;
        end
        r_rd_data    <= r_mem[r_head];
        r_rd_written <= r_written[r_head];
        r_rd_pos     <= r_head;
    end

    assign o_head_chan = r_rd_written ? r_rd_data : r_rd_pos;
    assign o_count     = r_count;

endmodule

/* tb/channel_pool_allocator_tb.sv */
// Self-checking testbench for the channel pool allocator: directed and random requests.
`timescale 1ns / 100ps

module channel_pool_allocator_tb;

    localparam int NCH           = 24;
    localparam int SRC_W         = 16;
    localparam int LATENCY       = NCH + 2;
    localparam int IDLE_LIMIT    = 2000;
    localparam int ID_POOL_SIZE  = 28;
    localparam int MAX_UNTRACKED = 5;
    localparam int MAX_PRINTED   = 40;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One result beat, field by field.
    typedef struct packed {
        logic                          ok;
        logic [cpa_pkg::CHANNEL_W-1:0] channel;
        logic                          was_playing;
        logic                          stop_request;
        logic [cpa_pkg::COUNT_W-1:0]   active_count;
        logic                          free_available;
    } t_alloc_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       i_mode;
    logic [SRC_W-1:0] i_source_id;
    logic             i_stop;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic             i_cfg_data;
    logic             o_valid;
    logic             o_ok;
    logic [cpa_pkg::CHANNEL_W-1:0] o_channel;
    logic             o_was_playing;
    logic             o_stop_request;
    logic [cpa_pkg::COUNT_W-1:0]   o_active_count;
    logic             o_free_available;

    // Shadow copy of the pool: free list, source table and the tracking register.
    logic [cpa_pkg::CHANNEL_W-1:0] free_slot [NCH];
    int                   free_head;
    int                   free_tail;
    int                   free_cnt;
    logic                 tbl_valid [NCH];
    logic [SRC_W-1:0]     tbl_source [NCH];
    logic [cpa_pkg::CHANNEL_W-1:0] tbl_chan [NCH];
    logic                 track_cfg;

    t_alloc_result    pending_results[$];
    logic [SRC_W-1:0] id_pool [ID_POOL_SIZE];
    int               idle_pct;
    int               err_count;
    int               n_items;
    int               n_results;
    int               n_reuse;
    int               n_exhausted;
    int               n_stops;
    int               n_untracked;
    int               idle_cycles = 0;

    channel_pool_allocator #(
        .NUM_CHANNELS   (NCH),
        .SOURCE_ID_BITS (SRC_W)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_source_id      (i_source_id),
        .i_stop           (i_stop),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_ok             (o_ok),
        .o_channel        (o_channel),
        .o_was_playing    (o_was_playing),
        .o_stop_request   (o_stop_request),
        .o_active_count   (o_active_count),
        .o_free_available (o_free_available)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Print a mismatch (the first few only) and count it.
    task automatic note_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("ERROR: result %0d %s: got %0d, expected %0d", n_results, what, got, want);
        end
    endtask

    // Pool state right after reset.
    function automatic void reset_pool_shadow();
        for (int i = 0; i < NCH; i++) begin
            free_slot[i] = cpa_pkg::CHANNEL_W'(i);
            tbl_valid[i] = 1'b0;
            tbl_source[i] = '0;
            tbl_chan[i] = '0;
        end
        free_head = 0;
        free_tail = 0;
        free_cnt = NCH;
        track_cfg = 1'b1;
    endfunction

    // Table index that holds the source, or -1.
    function automatic int find_source(input logic [SRC_W-1:0] src);
        int hit;
        hit = -1;
        for (int i = 0; i < NCH; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_source[i] == src) begin
                hit = i;
            end
        end
        return hit;
    endfunction

    // Apply one request to the shadow pool and return the result it must give.
    function automatic t_alloc_result allocate_channel(input logic [1:0] mode,
                                                       input logic [SRC_W-1:0] src,
                                                       input logic stop);
        t_alloc_result r;
        int hit;
        int active;
        logic placed;
        r = '0;
        hit = find_source(src);
        case (mode)
            cpa_pkg::MODE_ASSIGN: begin
                if (hit >= 0) begin
                    r.ok = 1'b1;
                    r.was_playing = 1'b1;
                    r.channel = tbl_chan[hit];
                    n_reuse++;
                end else if (free_cnt > 0) begin
                    r.ok = 1'b1;
                    r.channel = free_slot[free_head];
                    free_head = (free_head + 1) % NCH;
                    free_cnt--;
                    placed = 1'b0;
                    if (track_cfg) begin
                        for (int i = 0; i < NCH; i++) begin
                            if (!placed && !tbl_valid[i]) begin
                                tbl_valid[i] = 1'b1;
                                tbl_source[i] = src;
                                tbl_chan[i] = r.channel;
                                placed = 1'b1;
                            end
                        end
                    end else begin
                        // The channel leaves the pool for good.
                        n_untracked++;
                    end
                end else begin
                    n_exhausted++;
                end
            end
            cpa_pkg::MODE_RELEASE: begin
                if (hit >= 0) begin
                    r.ok = 1'b1;
                    r.stop_request = stop;
                    if (stop) n_stops++;
                    if (free_cnt < NCH) begin
                        free_slot[free_tail] = tbl_chan[hit];
                        free_tail = (free_tail + 1) % NCH;
                        free_cnt++;
                    end
                    tbl_valid[hit] = 1'b0;
                end
            end
            cpa_pkg::MODE_QUERY: begin
                r.ok = (hit >= 0);
            end
            default: begin
            end
        endcase
        active = 0;
        for (int i = 0; i < NCH; i++) begin
            if (tbl_valid[i]) active++;
        end
        r.active_count = cpa_pkg::COUNT_W'(active);
        r.free_available = (free_cnt > 0);
        return r;
    endfunction

    // Send one request beat and queue its expected result once it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [SRC_W-1:0] src,
                                input logic stop);
        @(posedge i_clk);
        if (idle_pct != 0) begin
            while (busy) @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_source_id <= src;
        i_stop <= stop;
        do @(posedge i_clk); while (busy);
        pending_results.insert(pending_results.size(), allocate_channel(mode, src, stop));
        n_items++;
        start <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // The register is only written while no request is in flight.
    task automatic write_track(input logic value);
        wait_results_drained();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        track_cfg = value;
    endtask

    // Lookups, reuse, releases with and without stop, unknown sources, unused mode.
    task automatic test_lookup_and_release();
        idle_pct = 0;
        send_request(cpa_pkg::MODE_QUERY, 16'h0000, 1'b0);
        send_request(cpa_pkg::MODE_ASSIGN, 16'h0000, 1'b0);
        send_request(cpa_pkg::MODE_ASSIGN, 16'hFFFF, 1'b1);
        send_request(cpa_pkg::MODE_ASSIGN, 16'h0000, 1'b0);
        send_request(cpa_pkg::MODE_QUERY, 16'hFFFF, 1'b0);
        send_request(cpa_pkg::MODE_RELEASE, 16'h5555, 1'b1);
        send_request(cpa_pkg::MODE_RELEASE, 16'hFFFF, 1'b1);
        send_request(cpa_pkg::MODE_RELEASE, 16'h0000, 1'b0);
        send_request(MODE_UNUSED, 16'hFFFF, 1'b1);
        send_request(cpa_pkg::MODE_QUERY, 16'hFFFF, 1'b0);
    endtask

    // With tracking off a channel is handed out but never recorded.
    task automatic test_untracked_assign();
        write_track(1'b0);
        send_request(cpa_pkg::MODE_ASSIGN, 16'hA5A5, 1'b0);
        send_request(cpa_pkg::MODE_QUERY, 16'hA5A5, 1'b0);
        send_request(cpa_pkg::MODE_RELEASE, 16'hA5A5, 1'b1);
        write_track(1'b1);
        send_request(cpa_pkg::MODE_ASSIGN, 16'hA5A5, 1'b0);
        send_request(cpa_pkg::MODE_QUERY, 16'hA5A5, 1'b0);
    endtask

    // Mixed traffic over a small set of sources so the pool fills and drains.
    task automatic test_random_traffic(input logic track, input int gap_pct, input int count,
                                       input bit pause_midway);
        logic [1:0]       mode;
        logic [SRC_W-1:0] src;
        int               pick;
        write_track(track);
        idle_pct = gap_pct;
        for (int n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2) wait_results_drained();
            pick = $urandom_range(99);
            if (pick < 45) mode = cpa_pkg::MODE_ASSIGN;
            else if (pick < 75) mode = cpa_pkg::MODE_RELEASE;
            else if (pick < 95) mode = cpa_pkg::MODE_QUERY;
            else mode = MODE_UNUSED;
            if ($urandom_range(99) < 85) src = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
            else src = SRC_W'($urandom());
            // Lost channels never come back, so keep their number small.
            if (!track_cfg && mode == cpa_pkg::MODE_ASSIGN && find_source(src) < 0
                    && n_untracked >= MAX_UNTRACKED) begin
                mode = cpa_pkg::MODE_QUERY;
            end
            send_request(mode, src, 1'($urandom_range(1)));
        end
    endtask

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected beat", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) note_mismatch("ok", o_ok, want.ok);
                if (o_channel !== want.channel) note_mismatch("channel", o_channel, want.channel);
                if (o_was_playing !== want.was_playing)
                    note_mismatch("was_playing", o_was_playing, want.was_playing);
                if (o_stop_request !== want.stop_request)
                    note_mismatch("stop_request", o_stop_request, want.stop_request);
                if (o_active_count !== want.active_count)
                    note_mismatch("active_count", o_active_count, want.active_count);
                if (o_free_available !== want.free_available)
                    note_mismatch("free_available", o_free_available, want.free_available);
            end
        end
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: no beat for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= cpa_pkg::MODE_ASSIGN;
        i_source_id <= '0;
        i_stop <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        err_count = 0;
        n_items = 0;
        n_results = 0;
        n_reuse = 0;
        n_exhausted = 0;
        n_stops = 0;
        n_untracked = 0;
        idle_pct = 0;
        reset_pool_shadow();
        for (int i = 0; i < ID_POOL_SIZE; i++) id_pool[i] = SRC_W'($urandom());
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lookup_and_release();
        test_untracked_assign();
        test_random_traffic(1'b1, 0, 300, 1'b0);
        test_random_traffic(1'b1, 68, 300, 1'b1);
        test_random_traffic(1'b0, 0, 300, 1'b0);
        test_random_traffic(1'b1, 22, 300, 1'b0);

        wait_results_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Covered %0d requests and %0d results: %0d reuses, %0d assigns with no channel,",
                 n_items, n_results, n_reuse, n_exhausted);
        $display("%0d releases with stop, %0d untracked assigns, tracking toggled on and off.",
                 n_stops, n_untracked);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
